/* hw/rtl/soef_pkg.sv */
package soef_pkg;

  localparam int COL_W = 12;
  localparam int PIX_W = 8;
  localparam int CFG_W = 13;
  localparam int RES_W = 24;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_ROW  = 1'b1;

  typedef struct packed {
    logic             last_of_run;
    logic [COL_W-1:0] edge_y;
    logic [COL_W-1:0] edge_x;
  } result_t;

  // results caused by one pixel, r0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

/* hw/rtl/soef_edge_logic.sv */
module soef_edge_logic #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [soef_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [soef_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [soef_pkg::PIX_W-1:0]           in_pixel,
  input  logic                                 q_room,
  output soef_pkg::push_t                      push
);
  import soef_pkg::*;

  localparam int CAP = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam logic [CFG_W-1:0] CAP_W = CFG_W'(CAP);
  localparam logic [COL_W-1:0] CAP_LAST = COL_W'(CAP - 1);

  logic [CFG_W-1:0] row_width_r;
  logic [COL_W-1:0] scan_row_r;
  logic             pix_valid_r;
  logic [PIX_W-1:0] pix_r;
  logic [COL_W-1:0] cc_r, cc_nxt;
  logic             pn_r, pn_nxt;
  logic             oe_r, oe_nxt;

  logic             proc;
  logic             nz;
  logic             trans;
  logic             end_row;
  logic             second;
  logic [COL_W-1:0] last_col;
  logic [COL_W-1:0] x1;
  logic [CFG_W-1:0] w_m1;

  assign proc     = pix_valid_r && q_room;
  assign in_ready = !pix_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= CFG_W'(640);
      scan_row_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH: row_width_r <= cfg_wdata;
        REG_SCAN_ROW:  scan_row_r  <= cfg_wdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_ready) begin
      pix_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix_r <= in_pixel;
    end
  end

  always_comb begin
    w_m1 = row_width_r - CFG_W'(1);
    if (row_width_r == '0) begin
      last_col = '0;
    end else if (row_width_r > CAP_W) begin
      last_col = CAP_LAST;
    end else begin
      last_col = w_m1[COL_W-1:0];
    end
  end

  always_comb begin
    nz      = (pix_r != '0);
    trans   = (nz != pn_r);
    x1      = pn_r ? (cc_r - COL_W'(1)) : cc_r;
    end_row = (cc_r >= last_col);
    second  = end_row && (oe_r ^ trans);

    push.n              = proc ? ({1'b0, trans} + {1'b0, second}) : 2'd0;
    push.r0.edge_x      = trans ? x1 : last_col;
    push.r0.edge_y      = scan_row_r;
    push.r0.last_of_run = !(trans && second);
    push.r1.edge_x      = last_col;
    push.r1.edge_y      = scan_row_r;
    push.r1.last_of_run = 1'b1;

    if (end_row) begin
      cc_nxt = '0;
      pn_nxt = 1'b0;
      oe_nxt = 1'b0;
    end else begin
      cc_nxt = cc_r + COL_W'(1);
      pn_nxt = nz;
      oe_nxt = oe_r ^ trans;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
      pn_r <= 1'b0;
      oe_r <= 1'b0;
    end else if (proc) begin
      cc_r <= cc_nxt;
      pn_r <= pn_nxt;
      oe_r <= oe_nxt;
    end
  end

  a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && end_row |=> cc_r == '0 && !pn_r && !oe_r)
    else $error("row state not cleared after last pixel");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !end_row |=> cc_r == COL_W'($past(cc_r) + COL_W'(1)))
    else $error("column counter did not advance");

  a_hold_no_room: assert property (@(posedge clk) disable iff (!rst_n)
    pix_valid_r && !q_room |=> pix_valid_r && $stable(pix_r) && $stable(cc_r))
    else $error("staged pixel lost while queue full");

endmodule

/* hw/rtl/soef_out_queue.sv */
module soef_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  soef_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output soef_pkg::result_t   out_item
);
  import soef_pkg::*;

  result_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  // a staged pixel may cause two results, so keep two slots free
  assign room      = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + QCNT_W'(push.n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + QPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push.n);
      rd_ptr_r <= rd_ptr_r + QPTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room)
    else $error("push into queue without room");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("waiting output item changed");

endmodule

/* hw/rtl/scanline_object_edge_finder.sv */
// Scanline object edge finder: takes the pixels of one binary image row left to
// right on in_*, one item per clock, and reports edge points on out_*. A pixel
// going nonzero reports its own column, a pixel going back to zero reports the
// previous column, and after the row's last pixel an odd edge count adds the
// last column to close an object at the right border. One pixel gives zero, one
// or two results; out_tlast marks the final result of each pixel. The pixel is
// registered, evaluated once the output queue has room, and its results land in
// a four-entry output queue whose head item drives out_* directly. Input
// runs at one pixel per cycle while the queue keeps two free slots; the output
// drains one result per cycle, so only long runs of two-result pixels or a
// stalled consumer slow the input. cfg_index 0 is row_width, 1 is scan_row;
// writes take effect at once and do not clear the row state.
module scanline_object_edge_finder #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [soef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [soef_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // pixel_value[7:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // edge_x[11:0], edge_y[23:12]
  output logic                            out_tlast
);
  import soef_pkg::*;

  push_t   push;
  logic    room;
  result_t item;

  soef_edge_logic #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata),
    .q_room    (room),
    .push      (push)
  );

  soef_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (item)
  );

  assign out_tdata = {item.edge_y, item.edge_x};
  assign out_tlast = item.last_of_run;

endmodule
